[design/gsd_pkg.sv]
// gsd_pkg: shared types and constants for the gear limited slew drive.
// No dependencies; used by the submodules and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gsd_pkg;

  localparam int unsigned NUM_LIMITS = 8;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned REQ_W      = 9;
  localparam int unsigned DRIVE_W    = 8;
  // Working width for slew math: holds +/-255 and current speed +/- step.
  localparam int unsigned CALC_W     = 10;

  localparam logic signed [CALC_W-1:0] NOISE_THRESHOLD = 10'sd10;
  localparam logic signed [CALC_W-1:0] SLEW_STEP       = 10'sd3;
  localparam logic signed [CALC_W-1:0] DRIVE_MAX       = 10'sd127;

  typedef enum logic [1:0] {
    GEAR_REVERSE      = 2'd0,
    GEAR_LOW          = 2'd1,
    GEAR_HIGH         = 2'd2,
    GEAR_FAST_REVERSE = 2'd3
  } gear_t;

  typedef enum logic [INDEX_W-1:0] {
    LOW_GEAR_LIMIT           = 3'd0,
    HIGH_GEAR_LIMIT          = 3'd1,
    REVERSE_GEAR_LIMIT       = 3'd2,
    REVERSE_HIGH_LIMIT       = 3'd3,
    BOOST_LOW_LIMIT          = 3'd4,
    BOOST_HIGH_LIMIT         = 3'd5,
    BOOST_REVERSE_LIMIT      = 3'd6,
    BOOST_REVERSE_HIGH_LIMIT = 3'd7
  } limit_idx_t;

  typedef logic signed [LIMIT_W-1:0] limit_t;

  localparam limit_t LIMIT_RESET [NUM_LIMITS] = '{
    8'sd64, 8'sd108, -8'sd64, -8'sd108, 8'sd74, 8'sd127, -8'sd64, -8'sd127
  };

  // Configuration write, as seen by the limit register file.
  typedef struct packed {
    logic                 en;
    logic [INDEX_W-1:0]   index;
    logic [LIMIT_W-1:0]   data;
  } cfg_wr_t;

  // Limits chosen for the item in flight.
  typedef struct packed {
    limit_t primary;    // limit picked by gear and boost
    limit_t secondary;  // boost fast-reverse limit
    logic   dual;       // apply the secondary clip as well
  } limit_sel_t;

endpackage

`default_nettype wire

[design/gsd_if.sv]
// gsd_if: valid/ready channel interfaces for drive requests and drive results.
// Depends on nothing but the field widths given here.
`timescale 1ns / 1ps
`default_nettype none

interface gsd_in_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] speed_request;
  logic [1:0]        gear;
  logic              boost;
  logic              drift;

  modport source (output valid, speed_request, gear, boost, drift, input ready);
  modport sink   (input valid, speed_request, gear, boost, drift, output ready);
endinterface

interface gsd_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] front_speed;
  logic signed [7:0] rear_speed;

  modport source (output valid, front_speed, rear_speed, input ready);
  modport sink   (input valid, front_speed, rear_speed, output ready);
endinterface

`default_nettype wire

[design/gsd_limit_regs.sv]
// gsd_limit_regs: eight signed clip limit registers and gear/boost selection.
// Depends on gsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsd_limit_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gsd_pkg::cfg_wr_t   cfg_wr,
  input  wire gsd_pkg::gear_t     gear,
  input  wire logic               boost,
  output gsd_pkg::limit_sel_t     sel
);

  gsd_pkg::limit_t limits [gsd_pkg::NUM_LIMITS];
  gsd_pkg::limit_idx_t base_idx;
  gsd_pkg::limit_idx_t pick_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gsd_pkg::NUM_LIMITS; i++) begin
        limits[i] <= gsd_pkg::LIMIT_RESET[i];
      end
    end else if (cfg_wr.en) begin
      limits[cfg_wr.index] <= gsd_pkg::limit_t'(cfg_wr.data);
    end
  end

  // Map gear onto the non-boost slot, then move to the boost set when boost is set.
  always_comb begin
    case (gear)
      gsd_pkg::GEAR_REVERSE:      base_idx = gsd_pkg::REVERSE_GEAR_LIMIT;
      gsd_pkg::GEAR_LOW:          base_idx = gsd_pkg::LOW_GEAR_LIMIT;
      gsd_pkg::GEAR_HIGH:         base_idx = gsd_pkg::HIGH_GEAR_LIMIT;
      gsd_pkg::GEAR_FAST_REVERSE: base_idx = gsd_pkg::REVERSE_HIGH_LIMIT;
      default:                    base_idx = gsd_pkg::LOW_GEAR_LIMIT;
    endcase
    pick_idx = gsd_pkg::limit_idx_t'({boost, base_idx[1:0]});
    sel.primary   = limits[pick_idx];
    sel.secondary = limits[gsd_pkg::BOOST_REVERSE_HIGH_LIMIT];
    sel.dual      = boost && (gear == gsd_pkg::GEAR_REVERSE);
  end

endmodule

`default_nettype wire

[design/gsd_drive_calc.sv]
// gsd_drive_calc: one tick of gear clip, slew limit, ramp-down and drift logic.
// Depends on gsd_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module gsd_drive_calc (
  input  wire logic signed [8:0]  speed_request,
  input  wire logic               drift,
  input  wire gsd_pkg::limit_sel_t sel,
  input  wire logic signed [7:0]  current_speed,
  output logic signed [7:0]       front_speed,
  output logic signed [7:0]       rear_speed
);

  typedef logic signed [gsd_pkg::CALC_W-1:0] calc_t;

  function automatic calc_t clip_val(input calc_t v, input calc_t lim);
    calc_t r;
    r = v;
    if (v > 0 && v > lim) r = lim;
    if (v < 0 && v < lim) r = lim;
    return r;
  endfunction

  function automatic logic signed [7:0] sat_drive(input calc_t v);
    calc_t r;
    r = v;
    if (v > gsd_pkg::DRIVE_MAX)  r = gsd_pkg::DRIVE_MAX;
    if (v < -gsd_pkg::DRIVE_MAX) r = -gsd_pkg::DRIVE_MAX;
    return r[7:0];
  endfunction

  calc_t req, lim_a, lim_b, cur;
  calc_t geared, clipped, mag, slewed, ramp, ramp_mag;

  always_comb begin
    req   = {speed_request[8], speed_request};
    lim_a = {{2{sel.primary[7]}}, sel.primary};
    lim_b = {{2{sel.secondary[7]}}, sel.secondary};
    cur   = {{2{current_speed[7]}}, current_speed};

    geared  = clip_val(req, lim_a);
    clipped = sel.dual ? clip_val(geared, lim_b) : geared;
    mag     = (clipped < 0) ? -clipped : clipped;

    // Drive: limit the step away from the current speed.
    if (clipped < 0) begin
      slewed = clip_val(clipped, cur - gsd_pkg::SLEW_STEP);
    end else begin
      slewed = clip_val(clipped, cur + gsd_pkg::SLEW_STEP);
    end

    // Coast: step toward zero, snap small values to zero.
    if (cur > 0) begin
      ramp = cur - gsd_pkg::SLEW_STEP;
    end else if (cur < 0) begin
      ramp = cur + gsd_pkg::SLEW_STEP;
    end else begin
      ramp = cur;
    end
    ramp_mag = (ramp < 0) ? -ramp : ramp;
    if (ramp_mag < gsd_pkg::NOISE_THRESHOLD) begin
      ramp = '0;
    end

    if (mag > gsd_pkg::NOISE_THRESHOLD) begin
      front_speed = sat_drive(slewed);
      rear_speed  = drift ? 8'sd0 : front_speed;
    end else begin
      front_speed = sat_drive(ramp);
      rear_speed  = front_speed;
    end
  end

endmodule

`default_nettype wire

[design/gear_limited_slew_drive.sv]
// gear_limited_slew_drive: top level of the gear limited slew drive controller.
// Depends on gsd_pkg, gsd_if, gsd_limit_regs and gsd_drive_calc.
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Dir | Handshake     | Payload
// -----------+-----+---------------+------------------------------------------
// drive_in   | in  | valid / ready | speed_request s9, gear u2, boost, drift
// drive_out  | out | valid / ready | front_speed s8, rear_speed s8
// cfg        | in  | cfg_wr_en     | cfg_index u3, cfg_wr_data s8 (no read)
//
// One tick per cycle unless the output stalls: a transfer lands in the input
// register, then an advance loads the result register and the current speed
// from it. The current speed register is the only loop.
// Synchronous reset clears both valid flags and the current speed and reloads
// the limit registers. A stalled output holds its result; the input register
// takes a new item in the same cycle that the result register drains.

module gear_limited_slew_drive (
  input  wire logic        clk,
  input  wire logic        rst,
  gsd_in_if.sink           drive_in,
  gsd_out_if.source        drive_out,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wr_data
);

  // Input register.
  logic              in_valid;
  logic signed [8:0] in_speed;
  logic [1:0]        in_gear;
  logic              in_boost;
  logic              in_drift;

  // Result register and slew state.
  logic              out_valid;
  logic signed [7:0] out_front;
  logic signed [7:0] out_rear;
  logic signed [7:0] current_speed;

  logic              advance;
  logic              in_xfer;
  logic signed [7:0] front_next;
  logic signed [7:0] rear_next;

  gsd_pkg::cfg_wr_t    cfg_wr;
  gsd_pkg::limit_sel_t limit_sel;

  // Advance a valid input register whenever the result register is empty or draining.
  assign advance        = in_valid && (!out_valid || drive_out.ready);
  assign drive_in.ready = !in_valid || advance;
  assign in_xfer        = drive_in.valid && drive_in.ready;

  assign drive_out.valid       = out_valid;
  assign drive_out.front_speed = out_front;
  assign drive_out.rear_speed  = out_rear;

  assign cfg_wr.en    = cfg_wr_en;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_wr_data;

  gsd_limit_regs u_limits (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .gear   (gsd_pkg::gear_t'(in_gear)),
    .boost  (in_boost),
    .sel    (limit_sel)
  );

  gsd_drive_calc u_calc (
    .speed_request (in_speed),
    .drift         (in_drift),
    .sel           (limit_sel),
    .current_speed (current_speed),
    .front_speed   (front_next),
    .rear_speed    (rear_next)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      current_speed <= '0;
    end else begin
      if (drive_in.ready) begin
        in_valid <= drive_in.valid;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        current_speed <= front_next;
      end else if (drive_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold unless a transfer or an advance loads it.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_speed <= drive_in.speed_request;
      in_gear  <= drive_in.gear;
      in_boost <= drive_in.boost;
      in_drift <= drive_in.drift;
    end
    if (advance) begin
      out_front <= front_next;
      out_rear  <= rear_next;
    end
  end

`ifndef SYNTHESIS
  // Front drive is saturated to the symmetric range.
  a_front_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_front != -8'sd128)
    else $error("front speed outside drive range");

  // Rear drive is the front value or zero under drift.
  a_rear_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_rear == out_front || out_rear == 8'sd0))
    else $error("rear speed neither front speed nor zero");

  // Slew state tracks the last produced front value.
  a_state_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> current_speed == out_front)
    else $error("current speed out of step with result");

  // A pending result with a full input register blocks new transfers.
  a_block_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !drive_out.ready) |-> !drive_in.ready)
    else $error("input accepted while pipeline is full");
`endif

endmodule

`default_nettype wire
